// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on the rising edge, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tsd_pkg.sv =====
package tsd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_IGNORE = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [8:0] LAST_POS  = 9'd511;
  localparam logic [8:0] CHK_AT    = 9'd148;
  localparam logic [8:0] CHK_END   = 9'd156;
  localparam logic [8:0] SIZE_AT   = 9'd124;
  localparam logic [8:0] SIZE_END  = 9'd136;
  localparam logic [8:0] TYPE_AT   = 9'd156;
  localparam logic [8:0] MAGIC_AT  = 9'd257;
  localparam logic [8:0] MAGIC_END = 9'd262;

  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic        produce;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] size;
    logic [7:0]  etype;
    logic        last;
  } result_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      default: c = 8'h72;
    endcase
    return c;
  endfunction

  // Digits 0-9 shift in as octal; anything else leaves the value alone.
  function automatic logic [31:0] octal_step(input logic [31:0] acc, input logic [7:0] c);
    logic [31:0] r;
    if (c < CHAR_ZERO || c > CHAR_NINE) begin
      r = acc;
    end else begin
      r = {acc[28:0], 3'b000} + {28'd0, c[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/tsd_input_reg.sv =====
module tsd_input_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic held_valid_next;

  assign in_stall = held_valid && !advance;

  always_comb begin
    if (in_valid && !in_stall) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end else begin
      held_valid_next = held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ===== hdl/tsd_parser.sv =====
`include "assert_macros.svh"

module tsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_in,
  output tsd_pkg::result_t res
);

  tsd_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [16:0] header_sum, header_sum_next;
  logic [31:0] stored_checksum, stored_checksum_next;
  logic [31:0] size_value, size_value_next;
  logic        magic_match, magic_match_next;
  logic [7:0]  type_value, type_value_next;
  logic [8:0]  pad_left, pad_left_next;

  logic [8:0]  pos;
  logic [31:0] count_inc;
  logic [16:0] sum_n;
  logic [31:0] chk_n;
  logic [31:0] size_n;
  logic [7:0]  type_n;
  logic        magic_n;
  logic [8:0]  pad_calc;
  logic [8:0]  pad_dec;

  assign pos       = byte_count[8:0];
  assign count_inc = byte_count + 32'd1;
  assign pad_calc  = 9'd0 - size_value[8:0];
  assign pad_dec   = pad_left - 9'd1;

  always_comb begin
    sum_n   = header_sum;
    chk_n   = stored_checksum;
    size_n  = size_value;
    type_n  = type_value;
    magic_n = magic_match;
    if (pos >= tsd_pkg::CHK_AT && pos < tsd_pkg::CHK_END) begin
      sum_n = header_sum + {9'd0, tsd_pkg::CHAR_BLANK};
      chk_n = tsd_pkg::octal_step(stored_checksum, data_in);
    end else begin
      sum_n = header_sum + {9'd0, data_in};
    end
    if (pos >= tsd_pkg::SIZE_AT && pos < tsd_pkg::SIZE_END) begin
      size_n = tsd_pkg::octal_step(size_value, data_in);
    end
    if (pos == tsd_pkg::TYPE_AT) begin
      type_n = data_in;
    end
    if (pos >= tsd_pkg::MAGIC_AT && pos < tsd_pkg::MAGIC_END) begin
      if (data_in != tsd_pkg::magic_char(3'(pos - tsd_pkg::MAGIC_AT))) begin
        magic_n = 1'b0;
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    header_sum_next      = header_sum;
    stored_checksum_next = stored_checksum;
    size_value_next      = size_value;
    magic_match_next     = magic_match;
    type_value_next      = type_value;
    pad_left_next        = pad_left;
    res                  = '0;
    if (step) begin
      unique case (phase)
        tsd_pkg::PH_HALT: begin
          res.produce = 1'b1;
          res.kind    = tsd_pkg::KIND_ERROR;
        end
        tsd_pkg::PH_DATA: begin
          res.produce     = 1'b1;
          res.kind        = tsd_pkg::KIND_DATA;
          res.data        = data_in;
          byte_count_next = count_inc;
          if (count_inc == size_value) begin
            res.last        = 1'b1;
            pad_left_next   = pad_calc;
            byte_count_next = '0;
            if (pad_calc != 9'd0) begin
              phase_next = tsd_pkg::PH_SKIP;
            end else begin
              phase_next           = tsd_pkg::PH_HEADER;
              header_sum_next      = '0;
              stored_checksum_next = '0;
              size_value_next      = '0;
              magic_match_next     = 1'b1;
              type_value_next      = '0;
            end
          end
        end
        tsd_pkg::PH_SKIP: begin
          pad_left_next = pad_dec;
          if (pad_dec == 9'd0) begin
            phase_next           = tsd_pkg::PH_HEADER;
            byte_count_next      = '0;
            header_sum_next      = '0;
            stored_checksum_next = '0;
            size_value_next      = '0;
            magic_match_next     = 1'b1;
            type_value_next      = '0;
          end
        end
        tsd_pkg::PH_HEADER: begin
          header_sum_next      = sum_n;
          stored_checksum_next = chk_n;
          size_value_next      = size_n;
          type_value_next      = type_n;
          magic_match_next     = magic_n;
          byte_count_next      = {23'd0, pos} + 32'd1;
          if (pos == tsd_pkg::LAST_POS) begin
            res.produce = 1'b1;
            if (!magic_n) begin
              res.kind             = tsd_pkg::KIND_IGNORE;
              byte_count_next      = '0;
              header_sum_next      = '0;
              stored_checksum_next = '0;
              size_value_next      = '0;
              magic_match_next     = 1'b1;
              type_value_next      = '0;
            end else if ({15'd0, sum_n} != chk_n) begin
              res.kind        = tsd_pkg::KIND_ERROR;
              phase_next      = tsd_pkg::PH_HALT;
              byte_count_next = '0;
            end else begin
              res.kind  = tsd_pkg::KIND_ACCEPT;
              res.size  = size_n;
              res.etype = type_n;
              if (type_n == tsd_pkg::CHAR_ZERO && size_n != 32'd0) begin
                phase_next      = tsd_pkg::PH_DATA;
                byte_count_next = '0;
              end else begin
                byte_count_next      = '0;
                header_sum_next      = '0;
                stored_checksum_next = '0;
                size_value_next      = '0;
                magic_match_next     = 1'b1;
                type_value_next      = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tsd_pkg::PH_HEADER;
      byte_count      <= '0;
      header_sum      <= '0;
      stored_checksum <= '0;
      size_value      <= '0;
      magic_match     <= 1'b1;
      type_value      <= '0;
      pad_left        <= '0;
    end else begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      header_sum      <= header_sum_next;
      stored_checksum <= stored_checksum_next;
      size_value      <= size_value_next;
      magic_match     <= magic_match_next;
      type_value      <= type_value_next;
      pad_left        <= pad_left_next;
    end
  end

  `ASSERT_NEXT(a_halt_sticky, clk, rst, phase == tsd_pkg::PH_HALT,
               phase == tsd_pkg::PH_HALT, "halt state left without reset")
  `ASSERT_IMPL(a_halt_reports, clk, rst, step && phase == tsd_pkg::PH_HALT,
               res.produce && res.kind == tsd_pkg::KIND_ERROR, "halted byte not reported")
  `ASSERT_IMPL(a_skip_silent, clk, rst, phase == tsd_pkg::PH_SKIP,
               !res.produce && pad_left != 9'd0, "pad byte produced a result")
  `ASSERT_IMPL(a_header_bound, clk, rst, phase == tsd_pkg::PH_HEADER,
               byte_count < 32'd512, "header offset past block end")

endmodule

// ===== hdl/tsd_output_reg.sv =====
module tsd_output_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tsd_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       result_kind,
  output logic [7:0]       out_byte,
  output logic [31:0]      entry_size,
  output logic [7:0]       entry_type,
  output logic             last_data
);

  logic out_valid_next;

  assign free = !out_valid || !out_stall;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= res.kind;
      out_byte    <= res.data;
      entry_size  <= res.size;
      entry_type  <= res.etype;
      last_data   <= res.last;
    end
  end

endmodule

// ===== hdl/tar_stream_deframer_unit.sv =====
// A byte held in the input register passes through the combinational parser into the result register.
// Throughput: one byte per cycle; a stalled result register holds back the input register.
// Header, data and pad bytes all move at that rate; pad and mid-header bytes give no result.
// Reset (rst, synchronous, active high) returns the parser to header collection,
// empties both registers and clears the halt state; no clearing pass follows.
module tar_stream_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] entry_size,
  output logic [7:0]  entry_type,
  output logic        last_data
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             free;
  logic             advance;
  tsd_pkg::result_t res;

  assign advance = held_valid && free;

  tsd_input_reg u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  tsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .data_in (held_byte),
    .res     (res)
  );

  tsd_output_reg u_output (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && res.produce),
    .res         (res),
    .free        (free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .out_byte    (out_byte),
    .entry_size  (entry_size),
    .entry_type  (entry_type),
    .last_data   (last_data)
  );

endmodule
